[hw/rtl/sha256_pkg.sv]
// Shared constants, types and round functions for the SHA-256 hasher.
package sha256_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned ROUNDS      = 64;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned LENGTH_POS  = 56;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load_byte;   // shift a byte into the block window
      logic [7:0] load_value;  // byte to shift in
      logic       add_bits;    // count eight more message bits
      logic       start;       // copy hash words into working vars, round 0
      logic       round;       // run one compression round
      logic       finish;      // add working vars into hash words
      logic       rearm;       // restore initial hash, clear length
      logic       shift_out;   // rotate hash words by one for output
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [31:0] top_word;   // hash word emitted next
      logic [7:0]  len_byte;   // length byte selected by index
   } dp_stat_type;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic logic [31:0] initial_hash(input logic [2:0] idx);
      logic [31:0] h [0:7];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

[hw/rtl/sha256_datapath.sv]
// Datapath: block window, message schedule, round unit, hash and length registers.
module sha256_datapath
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic [5:0]  round_idx,
   input  logic [2:0]  len_idx,
   output dp_stat_type stat
);

   // Sixteen-word sliding window; bytes shift in at the low end of word 15
   logic [31:0] w_ff [0:15];
   logic [31:0] w_in [0:15];
   logic [31:0] h_ff [0:7];
   logic [31:0] h_in [0:7];
   logic [31:0] v_ff [0:7];
   logic [31:0] v_in [0:7];
   logic [63:0] bits_ff, bits_in;

   logic [31:0] s0, s1, w_next, t1, t2, e, a;

   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_next = s1 + w_ff[9] + s0 + w_ff[0];
      e = v_ff[4];
      a = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(round_idx) + w_ff[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // Next values of window, working, hash and length registers
   always_comb begin
      w_in = w_ff;
      v_in = v_ff;
      h_in = h_ff;
      bits_in = bits_ff;
      if (cmd.load_byte) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i + 1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], cmd.load_value};
      end
      if (cmd.add_bits) begin
         bits_in = bits_ff + 64'd8;
      end
      if (cmd.start) begin
         v_in = h_ff;
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = w_next;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (cmd.finish) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
      if (cmd.shift_out) begin
         for (int i = 0; i < 7; i++) begin
            h_in[i] = h_ff[i + 1];
         end
         h_in[7] = h_ff[0];
      end
      if (cmd.rearm) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = initial_hash(3'(i));
         end
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= initial_hash(3'(i));
         end
         bits_ff <= '0;
      end else begin
         h_ff <= h_in;
         bits_ff <= bits_in;
      end
   end

   // Length byte, most significant first
   always_comb begin
      stat.top_word = h_ff[0];
      stat.len_byte = bits_ff[(7 - len_idx) * 8 +: 8];
   end

endmodule

[hw/rtl/sha256_control.sv]
// Controller: byte intake, padding sequence, round counter and digest output.
module sha256_control
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  in_byte,
   input  logic        in_valid_byte,
   input  logic        in_end,
   input  logic        in_fire,
   output logic        in_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic [5:0]  round_idx,
   output logic [2:0]  len_idx,
   output logic        out_valid,
   output logic [2:0]  out_index,
   input  logic        out_ready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [6:0] fill_ff, fill_in;    // bytes in window, 0..64
   logic [5:0] cnt_ff, cnt_in;      // round counter
   logic       closing_ff, closing_in; // message end pending
   logic       padded_ff, padded_in;   // 0x80 already placed
   logic       final_ff, final_in;     // current block holds the length
   logic [2:0] oidx_ff, oidx_in;

   assign round_idx = cnt_ff;
   assign len_idx   = fill_ff[2:0];
   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_index = oidx_ff;

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      closing_in = closing_ff;
      padded_in = padded_ff;
      final_in = final_ff;
      oidx_in = oidx_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_fire) begin
               if (in_valid_byte) begin
                  cmd.load_byte = 1'b1;
                  cmd.load_value = in_byte;
                  cmd.add_bits = 1'b1;
                  fill_in = fill_ff + 7'd1;
               end
               closing_in = in_end;
               padded_in = 1'b0;
               if (in_valid_byte && fill_ff == 7'(BLOCK_BYTES - 1)) begin
                  cmd.start = 1'b1;
                  cnt_in = '0;
                  final_in = 1'b0;
                  state_in = ST_ROUND;
               end else if (in_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.finish = 1'b1;
            fill_in = '0;
            oidx_in = '0;
            if (final_ff) begin
               state_in = ST_OUT;
            end else if (closing_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // Place 0x80, zeros, then length bytes when the block has room
            cmd.load_byte = 1'b1;
            if (!padded_ff) begin
               cmd.load_value = PAD_BYTE;
               padded_in = 1'b1;
            end else if (fill_ff >= 7'(LENGTH_POS) && final_ff) begin
               cmd.load_value = stat.len_byte;
            end else begin
               cmd.load_value = 8'h00;
            end
            fill_in = fill_ff + 7'd1;
            if (fill_ff < 7'(LENGTH_POS)) begin
               final_in = (fill_ff == 7'(LENGTH_POS - 1)) ? 1'b1 : 1'b0;
            end
            if (fill_ff == 7'(BLOCK_BYTES - 1)) begin
               cmd.start = 1'b1;
               cnt_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               cmd.shift_out = 1'b1;
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'(HASH_WORDS - 1)) begin
                  cmd.rearm = 1'b1;
                  closing_in = 1'b0;
                  final_in = 1'b0;
                  fill_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         cnt_ff <= '0;
         closing_ff <= 1'b0;
         padded_ff <= 1'b0;
         final_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         closing_ff <= closing_in;
         padded_ff <= padded_in;
         final_ff <= final_in;
         oidx_ff <= oidx_in;
      end
   end

endmodule

[hw/rtl/sha256_message_hasher.sv]
// Top level of the SHA-256 message hasher: controller plus datapath.
//
// Usage: feed a message one item per byte on the req_ channel. tdata[7:0] is
// the byte, tuser[0] says the byte is present and tlast closes the message
// (an item with tlast and no byte hashes what was sent before, possibly
// nothing). After the closing item the eight digest words come out on the
// rsp_ channel, word 0 (most significant) first, tlast on word 7.
// Throughput: one byte item per cycle into the block window while req_tready
// is high; the 64th byte of a block starts the round loop and then the add
// step, during which req_tready is low. A closing item first pads the window
// one byte per cycle until the block is full, and each padded block then runs
// the round loop and the add step; when the length does not fit, a second
// block is padded and hashed the same way before the first digest word
// appears. The eight words then leave one per cycle while rsp_tready is high.
// The round unit does one compression round per cycle and sets the block rate.
// Reset restores the initial hash values and clears the length count.
// A stalled receiver holds the current word; nothing is dropped and no
// new item is taken until the last word has been accepted.
module sha256_message_hasher
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
   output logic        rsp_tlast    // last_word
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [5:0]  round_idx;
   logic [2:0]  len_idx;
   logic [2:0]  out_index;
   logic        in_fire;

   assign in_fire = req_tvalid && req_tready;

   sha256_control u_control (
      .clock        (clock),
      .reset        (reset),
      .in_byte      (req_tdata),
      .in_valid_byte(req_tuser),
      .in_end       (req_tlast),
      .in_fire      (in_fire),
      .in_ready     (req_tready),
      .stat         (stat),
      .cmd          (cmd),
      .round_idx    (round_idx),
      .len_idx      (len_idx),
      .out_valid    (rsp_tvalid),
      .out_index    (out_index),
      .out_ready    (rsp_tready)
   );

   sha256_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .round_idx(round_idx),
      .len_idx  (len_idx),
      .stat     (stat)
   );

   assign rsp_tdata = {5'd0, out_index, stat.top_word};
   assign rsp_tlast = (out_index == 3'(HASH_WORDS - 1));

endmodule

[tb/tb_sha256_message_hasher.sv]
// Self-checking testbench for the SHA-256 message hasher with a digest scoreboard.

// Digest predictor and queue of expected words
class sha256_digest_board;
   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   int unsigned fill_count;
   logic [63:0] length_bits;
   logic [35:0] pending_words [$];
   int unsigned mismatch_count;
   int unsigned words_checked;
   int unsigned messages_closed;

   function void clear_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::initial_hash(i[2:0]);
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      fill_count = 0;
      length_bits = '0;
   endfunction

   function new();
      clear_hash();
      mismatch_count = 0;
      words_checked = 0;
      messages_closed = 0;
   endfunction

   function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, e, a;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         e = v[4];
         a = v[0];
         t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
            + sha256_pkg::round_k(i[5:0]) + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) ^ 32'h0;
         t2 = t2 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endfunction

   // Absorb one accepted item; queue eight digest words when it closes a message
   function void note_item(logic [7:0] value, logic has_byte, logic closes);
      if (has_byte) begin
         block_bytes[fill_count] = value;
         fill_count++;
         length_bits += 64'd8;
         if (fill_count == 64) begin
            compress();
            fill_count = 0;
         end
      end
      if (!closes) return;
      block_bytes[fill_count] = sha256_pkg::PAD_BYTE;
      fill_count++;
      if (fill_count > 56) begin
         for (int i = fill_count; i < 64; i++) block_bytes[i] = 8'h00;
         compress();
         fill_count = 0;
      end
      for (int i = fill_count; i < 56; i++) block_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[56+i] = length_bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++)
         pending_words.push_back({(i == 7) ? 1'b1 : 1'b0, i[2:0], hash_state[i]});
      messages_closed++;
      clear_hash();
   endfunction

   // Compare one accepted digest word against the oldest expectation
   function void check_word(logic [39:0] data, logic last);
      logic [35:0] want;
      words_checked++;
      if (pending_words.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected digest word %h last %b", data, last);
         return;
      end
      want = pending_words.pop_front();
      if (data[31:0] !== want[31:0] || data[34:32] !== want[34:32] || last !== want[35]
          || data[39:35] !== 5'd0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("digest mismatch: expected word %h index %0d last %b, got %h index %0d last %b",
                     want[31:0], want[34:32], want[35], data[31:0], data[34:32], last);
      end
   endfunction
endclass

module tb_sha256_message_hasher;
   import sha256_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] byte_valid
   logic        req_tlast = 1'b0;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [31:0] digest_word, [34:32] word_index
   logic        rsp_tlast;           // last_word

   sha256_digest_board board = new();
   int unsigned items_sent = 0;
   int unsigned hold_off_cycles = 0;
   bit stimulus_done = 1'b0;

   sha256_message_hasher dut (.*);

   always #10 clock = ~clock;

   // Gap length: mostly short, now and then long
   function automatic int unsigned gap_length();
      if ($urandom_range(0, 99) < 6) return $urandom_range(20, 120);
      if ($urandom_range(0, 99) < 50) return 0;
      return $urandom_range(1, 4);
   endfunction

   // Offer one item and hold it until accepted
   task automatic send_item(logic [7:0] value, logic has_byte, logic closes, bit idle_gaps);
      int unsigned gap;
      gap = idle_gaps ? gap_length() : 0;
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= has_byte;
      req_tlast  <= closes;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      board.note_item(value, has_byte, closes);
      items_sent++;
      @(negedge clock) req_tvalid <= 1'b0;
   endtask

   task automatic send_message(int unsigned length, bit close_with_byte, bit idle_gaps);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0, idle_gaps);
         send_item(8'($urandom), 1'b1, close_with_byte && (i == length - 1), idle_gaps);
      end
      if (!close_with_byte || length == 0) send_item(8'($urandom), 1'b0, 1'b1, idle_gaps);
   endtask

   // Receiver: random stalls, one long hold-off early in the run
   initial begin
      int unsigned stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (items_sent > 40 && hold_off_cycles == 0) begin
            rsp_tready <= 1'b0;
            repeat (600) begin
               @(negedge clock);
               hold_off_cycles++;
            end
         end
         stall = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // Check each accepted digest word
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata, rsp_tlast);

   // Stimulus
   initial begin
      int unsigned len;
      int unsigned limit_sizes [5];
      limit_sizes = '{55, 56, 63, 64, 65};
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // Empty message, "abc", idle items, byte with end, close without a byte
      send_item(8'h00, 1'b0, 1'b1, 1'b0);
      send_item(8'h61, 1'b1, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0, 1'b0);
      send_item(8'h62, 1'b1, 1'b0, 1'b0);
      send_item(8'h63, 1'b1, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0, 1'b0);
      send_item(8'hff, 1'b0, 1'b1, 1'b0);
      send_item(8'h55, 1'b0, 1'b0, 1'b0);
      send_item(8'haa, 1'b0, 1'b1, 1'b0);
      // Sizes around the one- and two-block padding limits and full blocks
      foreach (limit_sizes[k]) begin
         send_message(limit_sizes[k], k[0], 1'b1);
      end
      // Random messages, mostly short, some crossing blocks
      while (items_sent < 360) begin
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(21, 130);
         send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
      end
      // Drain
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Hashed %0d messages from %0d items; %0d digest words checked.",
               board.messages_closed, items_sent, board.words_checked);
      $display("Receiver held off for %0d cycles to back the block up.", hold_off_cycles);
      if (board.mismatch_count == 0 && board.pending_words.size() == 0)
         $display("tb_sha256_message_hasher OK");
      else
         $display("tb_sha256_message_hasher NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #40000000;
      $display("tb_sha256_message_hasher NOT OK");
      $finish;
   end
endmodule
